// ===== hdl/xml_entity_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// xml entity decoder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef XML_ENTITY_DECODER_ASSERT_SVH
`define XML_ENTITY_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define XED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xed: same-cycle check failed");

// next-cycle implication, disabled in reset
`define XED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xed: next-cycle check failed");

`endif

// ===== hdl/xed_pkg.sv =====
// ----------------------------------------------------------------------------
// xed_pkg
// types, entity tables and sizes shared by the xml entity decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xed_pkg;

    localparam int ENT_NUM     = 5;
    localparam int ENT_MAX_LEN = 6;
    localparam int PEND_DEPTH  = 5;
    localparam int OUT_DEPTH   = PEND_DEPTH + 1;
    localparam int COUNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int PEND_IDX_W  = $clog2(PEND_DEPTH);

    localparam logic [7:0] AMP_CHAR = 8'h26;

    typedef logic [COUNT_W-1:0]          count_t;
    typedef logic [PEND_IDX_W-1:0]       pend_idx_t;
    typedef logic [PEND_DEPTH-1:0][7:0]  pend_list_t;
    typedef logic [OUT_DEPTH-1:0][7:0]   emit_list_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_word_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       final_byte;
    } plain_word_t;

    // what one accepted byte does to the output list and the pending prefix
    typedef struct packed {
        emit_list_t emit_bytes;
        count_t     emit_count;
        logic       emit_final;
        count_t     pend_count;
        logic       pend_write;
        pend_idx_t  pend_index;
    } step_t;

    // &quot; &amp; &lt; &gt; &apos;, zero padded
    localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAX_LEN] = '{
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}
    };

    localparam count_t ENT_LEN [ENT_NUM] = '{
        count_t'(6), count_t'(5), count_t'(4), count_t'(4), count_t'(6)
    };

    localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{
        8'h22, 8'h26, 8'h3C, 8'h3E, 8'h27
    };

endpackage

// ===== hdl/xed_match.sv =====
// ----------------------------------------------------------------------------
// xed_match
// compares pending prefix plus new byte against the entity table and builds
// the list of bytes to emit and the next pending state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xed_match
(
    input  xed_pkg::text_word_t word,
    input  xed_pkg::pend_list_t pend_bytes,
    input  xed_pkg::count_t     pend_count,
    output xed_pkg::step_t      step
);

    xed_pkg::emit_list_t cand;
    xed_pkg::count_t     cnt;
    xed_pkg::count_t     n;
    logic [xed_pkg::ENT_NUM-1:0] prefix_hit;
    logic [xed_pkg::ENT_NUM-1:0] full_hit;
    logic [7:0]          full_char;
    logic                any_prefix;
    logic                any_full;
    logic                hit;

    function automatic xed_pkg::pend_idx_t pend_idx_t_cast(input xed_pkg::count_t c);
        return c[xed_pkg::PEND_IDX_W-1:0];
    endfunction

    always_comb
    begin
        // out-of-range count is taken as a full buffer
        if (pend_count > xed_pkg::count_t'(xed_pkg::PEND_DEPTH))
        begin
            cnt = xed_pkg::count_t'(xed_pkg::PEND_DEPTH);
        end
        else
        begin
            cnt = pend_count;
        end
        n = cnt + xed_pkg::count_t'(1);

        for (int i = 0; i < xed_pkg::OUT_DEPTH; i++)
        begin
            cand[i] = word.text_byte;
        end
        for (int i = 0; i < xed_pkg::PEND_DEPTH; i++)
        begin
            if (xed_pkg::count_t'(i) < cnt)
            begin
                cand[i] = pend_bytes[i];
            end
        end

        full_char = '0;
        for (int k = 0; k < xed_pkg::ENT_NUM; k++)
        begin
            hit = 1'b1;
            for (int i = 0; i < xed_pkg::ENT_MAX_LEN; i++)
            begin
                if (xed_pkg::count_t'(i) < n && cand[i] != xed_pkg::ENT_TEXT[k][i])
                begin
                    hit = 1'b0;
                end
            end
            prefix_hit[k] = hit && (n <= xed_pkg::ENT_LEN[k]);
            full_hit[k]   = prefix_hit[k] && (n == xed_pkg::ENT_LEN[k]);
            if (full_hit[k])
            begin
                full_char = full_char | xed_pkg::ENT_CHAR[k];
            end
        end
        any_prefix = |prefix_hit;
        any_full   = |full_hit;

        step.emit_bytes = cand;
        step.emit_count = '0;
        step.emit_final = word.end_of_text;
        step.pend_count = '0;
        step.pend_write = 1'b0;
        step.pend_index = pend_idx_t_cast(cnt);

        if (any_full)
        begin
            step.emit_bytes[0] = full_char;
            step.emit_count    = xed_pkg::count_t'(1);
        end
        else if (any_prefix)
        begin
            if (word.end_of_text)
            begin
                step.emit_count = n;
            end
            else
            begin
                step.pend_count = n;
                step.pend_write = 1'b1;
            end
        end
        else
        begin
            // flush held bytes; a fresh '&' opens a new prefix
            if (word.text_byte == xed_pkg::AMP_CHAR && !word.end_of_text)
            begin
                step.emit_count = cnt;
                step.pend_count = xed_pkg::count_t'(1);
                step.pend_write = 1'b1;
                step.pend_index = '0;
            end
            else
            begin
                step.emit_count = n;
            end
        end
    end

endmodule

// ===== hdl/xml_entity_decoder.sv =====
// ----------------------------------------------------------------------------
// xml_entity_decoder
// streaming decoder for the five predefined xml entities
// ----------------------------------------------------------------------------
// One text word is taken per cycle while text_ready is high, and its decoded
// bytes appear on the plain channel from the next cycle on, one byte per cycle
// while plain_ready is high. A word that yields at most one byte is followed
// by the next word in the very next cycle as long as the plain side keeps
// taking bytes. A word that flushes a held prefix yields up to six bytes, and
// the text side is held until the last of them leaves: the output list
// register drains through a single byte port. A partial entity is held
// internally and produces no byte until it completes, breaks, or the text ends.
`timescale 1ns / 1ps

module xml_entity_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  xed_pkg::text_word_t  text,
    output logic                 plain_valid,
    input  logic                 plain_ready,
    output xed_pkg::plain_word_t plain
);

    xed_pkg::pend_list_t pend_bytes_reg, pend_bytes_next;
    xed_pkg::count_t     pend_count_reg, pend_count_next;
    xed_pkg::emit_list_t out_bytes_reg,  out_bytes_next;
    xed_pkg::count_t     out_count_reg,  out_count_next;
    logic                out_final_reg,  out_final_next;

    xed_pkg::step_t      step;
    logic                text_accept;
    logic                plain_accept;

    xed_match u_match
    (
        .word       (text),
        .pend_bytes (pend_bytes_reg),
        .pend_count (pend_count_reg),
        .step       (step)
    );

    // take a new word once the list is empty or its last byte leaves now
    assign text_ready   = (out_count_reg == '0) ||
                          (out_count_reg == xed_pkg::count_t'(1) && plain_ready);
    assign text_accept  = text_valid && text_ready;
    assign plain_valid  = (out_count_reg != '0);
    assign plain_accept = plain_valid && plain_ready;

    assign plain.plain_byte = out_bytes_reg[0];
    assign plain.final_byte = out_final_reg && (out_count_reg == xed_pkg::count_t'(1));

    always_comb
    begin
        out_bytes_next  = out_bytes_reg;
        out_count_next  = out_count_reg;
        out_final_next  = out_final_reg;
        pend_bytes_next = pend_bytes_reg;
        pend_count_next = pend_count_reg;

        if (plain_accept)
        begin
            for (int i = 0; i < xed_pkg::OUT_DEPTH - 1; i++)
            begin
                out_bytes_next[i] = out_bytes_reg[i+1];
            end
            out_count_next = out_count_reg - xed_pkg::count_t'(1);
        end

        if (text_accept)
        begin
            out_bytes_next  = step.emit_bytes;
            out_count_next  = step.emit_count;
            out_final_next  = step.emit_final;
            pend_count_next = step.pend_count;
            if (step.pend_write)
            begin
                pend_bytes_next[step.pend_index] = text.text_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_count_reg <= '0;
            out_count_reg  <= '0;
            out_final_reg  <= 1'b0;
        end
        else
        begin
            pend_count_reg <= pend_count_next;
            out_count_reg  <= out_count_next;
            out_final_reg  <= out_final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_bytes_reg <= pend_bytes_next;
        out_bytes_reg  <= out_bytes_next;
    end

endmodule

// ===== hdl/xed_checker.sv =====
// ----------------------------------------------------------------------------
// xed_checker
// port-level checks for the xml entity decoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xml_entity_decoder_assert.svh"

module xed_port_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 text_valid,
    input logic                 text_ready,
    input xed_pkg::text_word_t  text,
    input logic                 plain_valid,
    input logic                 plain_ready,
    input xed_pkg::plain_word_t plain
);

    // a stalled output word holds
    `XED_ASSERT_NEXT(a_plain_hold, plain_valid && !plain_ready, plain_valid && $stable(plain))

    // with nothing waiting on the output, a text word is always taken
    `XED_ASSERT_NOW(a_idle_ready, !plain_valid, text_ready)

    // a stalled output blocks the text side
    `XED_ASSERT_NOW(a_stall_blocks, plain_valid && !plain_ready, !text_ready)

    // the end of a string always yields at least one byte
    `XED_ASSERT_NEXT(a_end_emits, text_valid && text_ready && text.end_of_text, plain_valid)

endmodule

bind xml_entity_decoder xed_port_checker u_checker (.*);

// ===== verif/xed_checker.sv =====
// ----------------------------------------------------------------------------
// xed_checker
// watches both channels of the xml entity decoder, predicts the plain words
// from every accepted text word and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xed_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    input  logic                 text_ready,
    input  xed_pkg::text_word_t  text,
    input  logic                 plain_valid,
    input  logic                 plain_ready,
    input  xed_pkg::plain_word_t plain,
    output int                   fail_count,
    output int                   outstanding,
    output int                   checked
);

    localparam int HOLD_DEPTH = 5;

    string      entity_text [5] = '{"&quot;", "&amp;", "&lt;", "&gt;", "&apos;"};
    logic [7:0] entity_char [5] = '{8'h22, 8'h26, 8'h3C, 8'h3E, 8'h27};

    // held prefix of an entity
    logic [7:0] held_bytes [HOLD_DEPTH];
    int         held_count;

    xed_pkg::plain_word_t plain_expect_q [$];
    int                   fails;
    int                   n_checked;

    function automatic void push_plain(input logic [7:0] b);
        plain_expect_q.push_back('{plain_byte: b, final_byte: 1'b0});
    endfunction

    function automatic void decode_text_word(input logic [7:0] b, input logic eot);
        logic [7:0] cand [HOLD_DEPTH + 1];
        int         n;
        int         hit;
        int         first_out;
        logic       is_prefix;
        logic       same;
        first_out = plain_expect_q.size();
        for (int i = 0; i < held_count; i++)
            cand[i] = held_bytes[i];
        cand[held_count] = b;
        n = held_count + 1;
        is_prefix = 1'b0;
        hit = -1;
        for (int k = 0; k < 5; k++)
        begin
            if (n <= entity_text[k].len())
            begin
                same = 1'b1;
                for (int i = 0; i < n; i++)
                    if (cand[i] != entity_text[k][i])
                        same = 1'b0;
                if (same)
                begin
                    is_prefix = 1'b1;
                    if (n == entity_text[k].len())
                        hit = k;
                end
            end
        end
        if (hit >= 0)
        begin
            push_plain(entity_char[hit]);
            held_count = 0;
        end
        else if (is_prefix)
        begin
            if (eot)
            begin
                for (int i = 0; i < n; i++)
                    push_plain(cand[i]);
                held_count = 0;
            end
            else
            begin
                held_bytes[held_count] = b;
                held_count = n;
            end
        end
        else
        begin
            // broken prefix goes out verbatim, then the byte itself unless it is an '&' that opens a new prefix
            for (int i = 0; i < held_count; i++)
                push_plain(cand[i]);
            held_count = 0;
            if (b == 8'h26 && !eot)
            begin
                held_bytes[0] = b;
                held_count = 1;
            end
            else
                push_plain(b);
        end
        if (eot && plain_expect_q.size() > first_out)
            plain_expect_q[plain_expect_q.size() - 1].final_byte = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        xed_pkg::plain_word_t want;
        if (!rst_n)
        begin
            held_count = 0;
            plain_expect_q.delete();
            fails = 0;
            n_checked = 0;
        end
        else
        begin
            if (text_valid && text_ready)
                decode_text_word(text.text_byte, text.end_of_text);
            if (plain_valid && plain_ready)
            begin
                if (plain_expect_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected plain word: expected none, actual byte %h final %b",
                             $time, plain.plain_byte, plain.final_byte);
                end
                else
                begin
                    want = plain_expect_q.pop_front();
                    n_checked++;
                    if (plain.plain_byte !== want.plain_byte)
                    begin
                        fails++;
                        $display("%0t: plain_byte mismatch: expected %h, actual %h",
                                 $time, want.plain_byte, plain.plain_byte);
                    end
                    if (plain.final_byte !== want.final_byte)
                    begin
                        fails++;
                        $display("%0t: final_byte mismatch: expected %b, actual %b",
                                 $time, want.final_byte, plain.final_byte);
                    end
                end
            end
        end
        fail_count  <= fails;
        checked     <= n_checked;
        outstanding <= plain_expect_q.size();
    end

endmodule

// ===== verif/tb_xml_entity_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_xml_entity_decoder
// drives strings of encoded text into the decoder with random idling on both
// sides; the checker beside the block predicts and compares every plain word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_xml_entity_decoder;

    localparam int RANDOM_WORDS = 290;
    localparam int QUIET_WORDS  = 60;
    localparam int LONG_HOLD    = 64;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 text_valid = 1'b0;
    logic                 text_ready;
    xed_pkg::text_word_t  text = '0;
    logic                 plain_valid;
    logic                 plain_ready = 1'b0;
    xed_pkg::plain_word_t plain;

    int   fail_count;
    int   outstanding;
    int   checked;
    int   words_sent = 0;
    int   strings_sent = 0;
    int   cycles = 0;
    logic quiet = 1'b0;
    logic hold_req = 1'b0;

    logic [7:0] str_q [$];

    xml_entity_decoder uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text        (text),
        .plain_valid (plain_valid),
        .plain_ready (plain_ready),
        .plain       (plain)
    );

    xed_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text        (text),
        .plain_valid (plain_valid),
        .plain_ready (plain_ready),
        .plain       (plain),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // plain side: random stall bursts plus one long hold-off
    initial
    begin
        int   stall_left;
        logic hold_taken;
        stall_left = 0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                plain_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                plain_ready <= 1'b0;
            end
            else
                plain_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eot);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        text       <= '{text_byte: b, end_of_text: eot};
        text_valid <= 1'b1;
        do @(posedge clk); while (!text_ready);
        words_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_word(str_q[i], i == str_q.size() - 1);
        str_q.delete();
        strings_sent++;
    endtask

    task automatic push_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            str_q.push_back(s[i]);
    endtask

    // one piece of a random string, weighted toward entities and broken ones
    task automatic add_random_token();
        int pick;
        int k;
        int cut;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, xed_pkg::ENT_NUM - 1);
        if (pick < 40)
        begin
            for (int i = 0; i < int'(xed_pkg::ENT_LEN[k]); i++)
                str_q.push_back(xed_pkg::ENT_TEXT[k][i]);
        end
        else if (pick < 60)
        begin
            cut = $urandom_range(1, int'(xed_pkg::ENT_LEN[k]) - 1);
            for (int i = 0; i < cut; i++)
                str_q.push_back(xed_pkg::ENT_TEXT[k][i]);
        end
        else if (pick < 66)
            str_q.push_back(xed_pkg::AMP_CHAR);
        else if (pick < 85)
            str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        else
            str_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int   base;
        logic hold_given;
        logic pause_given;
        hold_given = 1'b0;
        pause_given = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings
        push_chars("&g&lt;&quot;");
        send_string();
        push_chars("&amp;&apos");
        str_q.push_back(8'hFF);
        send_string();
        str_q.push_back(8'h00);
        send_string();
        push_chars("&gt");
        send_string();
        push_chars("&l&");
        send_string();

        base = words_sent;
        while (words_sent < base + RANDOM_WORDS)
        begin
            if (!hold_given && words_sent >= base + 100)
            begin
                hold_given = 1'b1;
                hold_req <= 1'b1;
            end
            if (!pause_given && words_sent >= base + 200)
            begin
                pause_given = 1'b1;
                text_valid <= 1'b0;
                do @(posedge clk); while (outstanding != 0);
            end
            if (words_sent >= base + RANDOM_WORDS - QUIET_WORDS)
                quiet <= 1'b1;
            repeat ($urandom_range(1, 6)) add_random_token();
            send_string();
        end
        text_valid <= 1'b0;

        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d text words in %0d strings, %0d plain words checked",
                 words_sent, strings_sent, checked);
        $display("covered all five entities, broken and trailing prefixes, a long stall");
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d failures, %0d plain words never arrived", fail_count, outstanding);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
